FILE: sv/sqe_pkg.sv
// Shared command and status codes for the stack and queue engine.
package sqe_pkg;

  localparam int WORD_W = 32;

  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_SWAP  = 3'd3,
    CMD_PRINT = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SHORT = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

endpackage

FILE: sv/sqe_ram.sv
// Word storage: one write port, one read port with registered read data.
module sqe_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [sqe_pkg::WORD_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [sqe_pkg::WORD_W-1:0] rdata
);

  logic [sqe_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/stack_queue_engine.sv
// Stack and queue engine top level: command sequencer around a word memory.
// Push, pop, peek and unknown commands: result registered from the exec state once the output is free.
// Swap: exec, swap A and swap B states (two reads, two write-backs on one port); result registered in swap B.
// Print all: top entry first, one result per cycle from the read port while the output is not stalled.
// The next word is accepted once the final result of the current one is registered.
// Synchronous rst clears count, bottom index, mode and control; the memory is not cleared.
module stack_queue_engine #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               queue_mode,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         command,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] data,
  output logic [1:0]         status,
  output logic               last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_SWAP_A = 5'b00100,
    S_SWAP_B = 5'b01000,
    S_PRINT  = 5'b10000
  } state_t;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  state_t state, state_next;
  logic              mode;
  logic [CW-1:0]     count;
  logic [AW-1:0]     bottom;
  logic [2:0]        cmd_q;
  logic [31:0]       val_q;
  logic [31:0]       tmp;
  logic [AW-1:0]     pidx;

  logic [CW-1:0]     cnt_m1, cnt_m2;
  logic [AW-1:0]     top_addr, below_addr, prev_addr, bdec, push_addr;
  logic              empty, full, short_n;
  logic              in_fire, out_free;

  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [31:0]       wr_data, rd_data;

  logic              emit, e_last;
  logic [31:0]       e_data;
  sqe_pkg::status_t  e_status;

  sqe_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    cnt_m1     = count - CW'(1);
    cnt_m2     = count - CW'(2);
    empty      = (count == '0);
    full       = (count == CW'(DEPTH));
    short_n    = (count < CW'(2));
    top_addr   = slot(bottom, cnt_m1[AW-1:0]);
    below_addr = slot(bottom, cnt_m2[AW-1:0]);
    prev_addr  = slot(bottom, pidx - AW'(1));
    bdec       = (bottom == '0) ? AW'(DEPTH - 1) : bottom - AW'(1);
    push_addr  = (mode && !empty) ? bdec : slot(bottom, count[AW-1:0]);
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    e_data     = '0;
    e_status   = sqe_pkg::ST_OK;
    e_last     = 1'b1;
    rd_en      = 1'b0;
    rd_addr    = top_addr;
    wr_en      = 1'b0;
    wr_addr    = push_addr;
    wr_data    = val_q;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          rd_en      = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_q)
          sqe_pkg::CMD_PUSH: begin
            emit     = 1'b1;
            e_status = full ? sqe_pkg::ST_FULL : sqe_pkg::ST_OK;
            wr_en    = out_free && !full;
          end
          sqe_pkg::CMD_POP: begin
            emit     = 1'b1;
            e_status = empty ? sqe_pkg::ST_EMPTY : sqe_pkg::ST_OK;
          end
          sqe_pkg::CMD_PEEK: begin
            emit     = 1'b1;
            e_status = empty ? sqe_pkg::ST_EMPTY : sqe_pkg::ST_OK;
            e_data   = empty ? '0 : rd_data;
          end
          sqe_pkg::CMD_SWAP: begin
            if (short_n) begin
              emit     = 1'b1;
              e_status = sqe_pkg::ST_SHORT;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = below_addr;
              state_next = S_SWAP_A;
            end
          end
          sqe_pkg::CMD_PRINT: begin
            if (empty) begin
              emit     = 1'b1;
              e_status = sqe_pkg::ST_EMPTY;
            end else begin
              state_next = S_PRINT;
            end
          end
          default: begin
            emit = 1'b1;
          end
        endcase
        if (emit && out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SWAP_A: begin
        wr_en      = 1'b1;
        wr_addr    = top_addr;
        wr_data    = rd_data;
        state_next = S_SWAP_B;
      end
      S_SWAP_B: begin
        wr_en   = 1'b1;
        wr_addr = below_addr;
        wr_data = tmp;
        emit    = 1'b1;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_PRINT: begin
        emit   = 1'b1;
        e_data = rd_data;
        e_last = (pidx == '0);
        if (out_free) begin
          if (pidx == '0) begin
            state_next = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = prev_addr;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= 1'b0;
      count     <= '0;
      bottom    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        mode <= queue_mode;
      end
      if (state == S_EXEC && out_free) begin
        if (cmd_q == sqe_pkg::CMD_PUSH && !full) begin
          count <= count + CW'(1);
          if (mode && !empty) begin
            bottom <= bdec;
          end
        end else if (cmd_q == sqe_pkg::CMD_POP && !empty) begin
          count <= cnt_m1;
        end
      end
      if (emit && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q <= command;
      val_q <= value;
    end
    if (state == S_EXEC) begin
      tmp  <= rd_data;
      pidx <= cnt_m1[AW-1:0];
    end else if (state == S_PRINT && out_free && pidx != '0) begin
      pidx <= pidx - AW'(1);
    end
    if (emit && out_free) begin
      data   <= e_data;
      status <= e_status;
      last   <= e_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_print_index: assert property (@(posedge clk) disable iff (rst)
    state == S_PRINT |-> CW'(pidx) < count)
    else $error("print index outside stored entries");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !wr_en)
    else $error("memory write while idle");

  a_swap_order: assert property (@(posedge clk) disable iff (rst)
    state == S_SWAP_A |=> state == S_SWAP_B)
    else $error("swap write-back sequence broken");

endmodule

FILE: sim/stack_queue_engine_tb.sv
// Self-checking testbench for the stack and queue engine: directed and random commands.
module stack_queue_engine_tb;

  localparam int DEPTH = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic [2:0]         command;
    logic signed [31:0] value;
  } cmd_item_t;

  typedef struct {
    logic signed [31:0] data;
    sqe_pkg::status_t   status;
    logic               last;
  } result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               queue_mode = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         command = sqe_pkg::CMD_PUSH;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] data;
  logic [1:0]         status;
  logic               last;

  // predicted engine state
  logic signed [31:0] eng_words [DEPTH];
  logic [4:0]         eng_bottom = '0;
  logic [5:0]         eng_count = '0;
  logic               eng_queue_mode = 1'b0;

  cmd_item_t pending_cmds [$];
  result_t   expected_results [$];
  result_t   want;
  int        mismatches = 0;
  int        cycles = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  int        hold_left = 0;
  logic      hold_req = 1'b0;
  logic      hold_started = 1'b0;
  logic      calm = 1'b0;

  stack_queue_engine #(.DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .queue_mode(queue_mode),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data      (data),
    .status    (status),
    .last      (last)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // depth is a power of two, so the 5-bit sum wraps as the ring does
  function automatic logic [4:0] ring_slot(input logic [5:0] offset);
    return eng_bottom + offset[4:0];
  endfunction

  function automatic void add_result(input logic signed [31:0] d, input sqe_pkg::status_t st,
                                     input logic lst);
    expected_results.push_back('{data: d, status: st, last: lst});
  endfunction

  function automatic void engine_step(input cmd_item_t it);
    logic [4:0]         top_slot;
    logic [4:0]         below_slot;
    logic signed [31:0] tmp;
    case (it.command)
      sqe_pkg::CMD_PUSH: begin
        if (eng_count == DEPTH) begin
          add_result('0, sqe_pkg::ST_FULL, 1'b1);
        end else begin
          if (eng_queue_mode && eng_count != 0) begin
            eng_bottom = eng_bottom - 5'd1;
            eng_words[eng_bottom] = it.value;
          end else begin
            eng_words[ring_slot(eng_count)] = it.value;
          end
          eng_count++;
          add_result('0, sqe_pkg::ST_OK, 1'b1);
        end
      end
      sqe_pkg::CMD_POP: begin
        if (eng_count == 0) begin
          add_result('0, sqe_pkg::ST_EMPTY, 1'b1);
        end else begin
          eng_count--;
          add_result('0, sqe_pkg::ST_OK, 1'b1);
        end
      end
      sqe_pkg::CMD_PEEK: begin
        if (eng_count == 0) add_result('0, sqe_pkg::ST_EMPTY, 1'b1);
        else add_result(eng_words[ring_slot(eng_count - 6'd1)], sqe_pkg::ST_OK, 1'b1);
      end
      sqe_pkg::CMD_SWAP: begin
        if (eng_count < 2) begin
          add_result('0, sqe_pkg::ST_SHORT, 1'b1);
        end else begin
          top_slot = ring_slot(eng_count - 6'd1);
          below_slot = ring_slot(eng_count - 6'd2);
          tmp = eng_words[top_slot];
          eng_words[top_slot] = eng_words[below_slot];
          eng_words[below_slot] = tmp;
          add_result('0, sqe_pkg::ST_OK, 1'b1);
        end
      end
      sqe_pkg::CMD_PRINT: begin
        if (eng_count == 0) begin
          add_result('0, sqe_pkg::ST_EMPTY, 1'b1);
        end else begin
          for (int i = eng_count; i > 0; i--)
            add_result(eng_words[ring_slot(6'(i - 1))], sqe_pkg::ST_OK, i == 1);
        end
      end
      default: add_result('0, sqe_pkg::ST_OK, 1'b1);
    endcase
  endfunction

  // driver: advance on acceptance, hold while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) engine_step(pending_cmds.pop_front());
      if (!(in_valid && in_stall)) begin
        if (in_gap == 0 && !calm && pending_cmds.size() != 0 && $urandom_range(0, 5) == 0)
          in_gap = $urandom_range(1, 8);
        if (in_gap != 0 || pending_cmds.size() == 0) begin
          in_valid <= 1'b0;
          if (in_gap != 0) in_gap--;
        end else begin
          in_valid <= 1'b1;
          command <= pending_cmds[0].command;
          value <= pending_cmds[0].value;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req && !hold_started) begin
      hold_started <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: compare each word against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: data %0d status %0d last %0d", data, status, last);
        end else begin
          want = expected_results.pop_front();
          if (data !== want.data || status !== want.status || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected data %0d status %0d last %0d, got %0d %0d %0d",
                       want.data, want.status, want.last, data, status, last);
          end
        end
      end
      if (out_gap != 0) out_gap--;
      else if (!calm && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 8);
      out_stall <= (out_gap != 0) || (hold_left != 0);
    end
  end

  task automatic write_mode(input logic m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    queue_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    eng_queue_mode = m;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (pending_cmds.size() != 0 || expected_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic void queue_cmd(input logic [2:0] c, input logic signed [31:0] v);
    pending_cmds.push_back('{command: c, value: v});
  endfunction

  function automatic cmd_item_t rand_cmd(input int push_w, input int pop_w);
    cmd_item_t it;
    int        roll;
    int        pick;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    it.value = $urandom;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: it.value = WORD_MIN;
        1: it.value = WORD_MAX;
        2: it.value = '0;
        default: it.value = -1;
      endcase
    end
    if (roll < push_w) it.command = sqe_pkg::CMD_PUSH;
    else if (roll < push_w + pop_w) it.command = sqe_pkg::CMD_POP;
    else if (pick < 30) it.command = sqe_pkg::CMD_PEEK;
    else if (pick < 60) it.command = sqe_pkg::CMD_SWAP;
    else if (pick < 85) it.command = sqe_pkg::CMD_PRINT;
    else it.command = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    return it;
  endfunction

  task automatic run_phase(input logic m, input int n, input int push_w, input int pop_w,
                           input logic squeeze, input logic quiet);
    write_mode(m);
    calm = quiet;
    if (squeeze) hold_req = 1'b1;
    repeat (n) pending_cmds.push_back(rand_cmd(push_w, pop_w));
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // stack mode: empty cases, short swap, extreme words, unknown commands
    write_mode(1'b0);
    queue_cmd(sqe_pkg::CMD_POP, '0);
    queue_cmd(sqe_pkg::CMD_PEEK, '0);
    queue_cmd(sqe_pkg::CMD_SWAP, '0);
    queue_cmd(sqe_pkg::CMD_PRINT, '0);
    queue_cmd(sqe_pkg::CMD_PUSH, WORD_MIN);
    queue_cmd(sqe_pkg::CMD_SWAP, '0);
    queue_cmd(sqe_pkg::CMD_PUSH, WORD_MAX);
    queue_cmd(sqe_pkg::CMD_PUSH, '0);
    queue_cmd(sqe_pkg::CMD_PUSH, -1);
    queue_cmd(sqe_pkg::CMD_PEEK, '0);
    queue_cmd(sqe_pkg::CMD_SWAP, '0);
    queue_cmd(sqe_pkg::CMD_PEEK, '0);
    queue_cmd(sqe_pkg::CMD_PRINT, '0);
    for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) queue_cmd(3'(c), WORD_MAX);
    queue_cmd(sqe_pkg::CMD_POP, WORD_MIN);
    wait_idle();

    // queue mode: feed at the bottom
    write_mode(1'b1);
    queue_cmd(sqe_pkg::CMD_PUSH, 32'sh1234_5678);
    queue_cmd(sqe_pkg::CMD_PUSH, 32'shA5A5_A5A5);
    queue_cmd(sqe_pkg::CMD_PRINT, '0);
    queue_cmd(sqe_pkg::CMD_POP, '0);
    queue_cmd(sqe_pkg::CMD_PEEK, '0);
    queue_cmd(sqe_pkg::CMD_SWAP, '0);
    wait_idle();

    run_phase(1'b0, 40, 70, 10, 1'b0, 1'b0);
    run_phase(1'b1, 45, 85, 5, 1'b1, 1'b0);
    run_phase(1'b1, 40, 15, 60, 1'b0, 1'b0);
    run_phase(1'b0, 35, 50, 25, 1'b0, 1'b0);
    run_phase(1'b1, 35, 60, 20, 1'b0, 1'b0);
    run_phase(1'b0, 35, 20, 55, 1'b0, 1'b1);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/sqe_pkg.sv
sv/sqe_ram.sv
sv/stack_queue_engine.sv
sim/stack_queue_engine_tb.sv
